/* rtl/gf256_congruence_transform_top_assert.svh */
// Assertion macros used by the checker of the congruence transform block.
`ifndef GF256_CONGRUENCE_TRANSFORM_TOP_ASSERT_SVH
`define GF256_CONGRUENCE_TRANSFORM_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define GCT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define GCT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gct_pkg.sv */
// Types and constants shared by the congruence transform modules.
package gct_pkg;

    // Field widths of the streaming items.
    localparam int IDX_W  = 5;
    localparam int VAL_W  = 8;
    localparam int PIDX_W = 10;
    localparam int CMD_W  = 2;

    // Command codes carried in s_tuser.
    localparam logic [CMD_W-1:0] CMD_LOAD_T  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_Q  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    // Kinds of result that the datapath can emit.
    localparam logic [1:0] EMIT_READ = 2'd0;
    localparam logic [1:0] EMIT_ZERO = 2'd1;
    localparam logic [1:0] EMIT_DONE = 2'd2;

    // Configuration register map.
    localparam logic       CFG_IDX_VARS = 1'b0;
    localparam logic [4:0] VARS_RESET   = 5'd31;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic             ld_t;       // write a transform entry
        logic             ld_q;       // write a quadratic entry
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             mac;        // one multiply-accumulate step
        logic             mac_b;      // second product pass (partial row times T)
        logic             first;      // first term of a sum
        logic             last;       // last term of a sum, store the result
        logic             fold;       // fold the mirror entry of P into the upper one
        logic             emit;       // produce a result transaction
        logic [1:0]       emit_kind;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] m;
        logic [IDX_W-1:0] p;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;               // the result register can take an emitted result
    } dp_status_t;

endpackage

/* rtl/gct_ctrl.sv */
// Sequencer that walks loads, the matrix product, the fold and packed reads.
module gct_ctrl #(
    parameter int MAX_DIM = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gct_pkg::CMD_W-1:0]     cmd_code,
    input  logic [gct_pkg::IDX_W-1:0]     row,
    input  logic [gct_pkg::IDX_W-1:0]     col,
    input  logic [gct_pkg::VAL_W-1:0]     entry_value,
    input  logic [gct_pkg::PIDX_W-1:0]    packed_index,
    input  logic [4:0]                    vars_in_use,
    input  gct_pkg::dp_status_t           status,
    output gct_pkg::dp_cmd_t              cmd
);
    import gct_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_A_MAC   = 4'd1;
    localparam logic [3:0] ST_A_DRAIN = 4'd2;
    localparam logic [3:0] ST_B_MAC   = 4'd3;
    localparam logic [3:0] ST_B_DRAIN = 4'd4;
    localparam logic [3:0] ST_FOLD    = 4'd5;
    localparam logic [3:0] ST_F_DRAIN = 4'd6;
    localparam logic [3:0] ST_DONE    = 4'd7;
    localparam logic [3:0] ST_WALK    = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [IDX_W-1:0]  l_reg, l_next;
    logic [IDX_W-1:0]  m_reg, m_next;
    logic [IDX_W-1:0]  p_reg, p_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [PIDX_W-1:0] rem_reg, rem_next;
    logic              cnt_reg, cnt_next;
    logic [IDX_W-1:0]  dlast;
    logic [IDX_W-1:0]  row_len;

    // Highest matrix index in use: the dimension is clamped to the storage size.
    always_comb begin
        if (int'(vars_in_use) > MAX_DIM - 1) begin
            dlast = IDX_W'(MAX_DIM - 1);
        end else begin
            dlast = vars_in_use;
        end
    end

    // Length of the packed row k of the upper triangle.
    assign row_len = dlast - k_reg;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        l_next     = l_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (cmd_code)
                        CMD_LOAD_T: begin
                            cmd.ld_t  = 1'b1;
                            cmd.row   = row;
                            cmd.col   = col;
                            cmd.value = entry_value;
                        end
                        CMD_LOAD_Q: begin
                            cmd.ld_q  = 1'b1;
                            cmd.row   = row;
                            cmd.col   = col;
                            cmd.value = entry_value;
                        end
                        CMD_COMPUTE: begin
                            l_next     = '0;
                            m_next     = '0;
                            p_next     = '0;
                            state_next = ST_A_MAC;
                        end
                        CMD_READ: begin
                            rem_next   = packed_index;
                            k_next     = '0;
                            state_next = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One row of transpose(T) * Q into the partial row.
            ST_A_MAC: begin
                cmd.mac   = 1'b1;
                cmd.first = (p_reg == '0);
                cmd.last  = (p_reg == dlast);
                cmd.l     = l_reg;
                cmd.m     = m_reg;
                cmd.p     = p_reg;
                if (p_reg == dlast) begin
                    p_next = '0;
                    if (m_reg == dlast) begin
                        m_next     = '0;
                        state_next = ST_A_DRAIN;
                    end else begin
                        m_next = m_reg + 1'b1;
                    end
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end

            // Let the last partial row writes land before they are read.
            ST_A_DRAIN: begin
                cnt_next = ~cnt_reg;
                if (cnt_reg) begin
                    state_next = ST_B_MAC;
                end
            end

            // The partial row times T gives one row of P.
            ST_B_MAC: begin
                cmd.mac   = 1'b1;
                cmd.mac_b = 1'b1;
                cmd.first = (p_reg == '0);
                cmd.last  = (p_reg == dlast);
                cmd.l     = l_reg;
                cmd.m     = m_reg;
                cmd.p     = p_reg;
                if (p_reg == dlast) begin
                    p_next = '0;
                    if (m_reg == dlast) begin
                        m_next = '0;
                        if (l_reg == dlast) begin
                            state_next = ST_B_DRAIN;
                        end else begin
                            l_next     = l_reg + 1'b1;
                            state_next = ST_A_MAC;
                        end
                    end else begin
                        m_next = m_reg + 1'b1;
                    end
                end else begin
                    p_next = p_reg + 1'b1;
                end
            end

            // Let the last row of P land, then start the fold at (0, 1).
            ST_B_DRAIN: begin
                cnt_next = ~cnt_reg;
                if (cnt_reg) begin
                    l_next = '0;
                    m_next = IDX_W'(1);
                    if (dlast == '0) begin
                        state_next = ST_F_DRAIN;
                    end else begin
                        state_next = ST_FOLD;
                    end
                end
            end

            // Each upper entry takes in its mirror below the diagonal.
            ST_FOLD: begin
                cmd.fold = 1'b1;
                cmd.l    = l_reg;
                cmd.m    = m_reg;
                if (m_reg == dlast) begin
                    if (l_reg + 1'b1 == dlast) begin
                        state_next = ST_F_DRAIN;
                    end else begin
                        l_next = l_reg + 1'b1;
                        m_next = l_reg + IDX_W'(2);
                    end
                end else begin
                    m_next = m_reg + 1'b1;
                end
            end

            ST_F_DRAIN: begin
                cnt_next = ~cnt_reg;
                if (cnt_reg) begin
                    state_next = ST_DONE;
                end
            end

            // Report completion of the compute command.
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_DONE;
                    state_next    = ST_IDLE;
                end
            end

            // Map the packed index to a matrix position, one packed row a cycle.
            ST_WALK: begin
                if (k_reg < dlast) begin
                    if (rem_reg >= PIDX_W'(row_len)) begin
                        rem_next = rem_reg - PIDX_W'(row_len);
                        k_next   = k_reg + 1'b1;
                    end else if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EMIT_READ;
                        cmd.l         = k_reg;
                        cmd.m         = k_reg + rem_reg[IDX_W-1:0];
                        state_next    = ST_IDLE;
                    end
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (rem_reg <= PIDX_W'(dlast)) begin
                        cmd.emit_kind = EMIT_READ;
                        cmd.l         = rem_reg[IDX_W-1:0];
                        cmd.m         = dlast;
                    end else begin
                        cmd.emit_kind = EMIT_ZERO;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and loop counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            l_reg     <= '0;
            m_reg     <= '0;
            p_reg     <= '0;
            k_reg     <= '0;
            rem_reg   <= '0;
            cnt_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            l_reg     <= l_next;
            m_reg     <= m_next;
            p_reg     <= p_next;
            k_reg     <= k_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/gct_datapath.sv */
// Matrix stores, GF(2^8) multiply-accumulate pipeline and the result register.
module gct_datapath #(
    parameter int MAX_DIM = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gct_pkg::dp_cmd_t             cmd,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [gct_pkg::VAL_W-1:0]    coefficient,
    output logic                         is_done,
    output gct_pkg::dp_status_t          status
);
    import gct_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_DIM);

    logic [VAL_W-1:0] t_mem [DEPTH];
    logic [VAL_W-1:0] q_mem [DEPTH];
    logic [VAL_W-1:0] p_mem [DEPTH];
    logic [VAL_W-1:0] part_mem [MAX_DIM];

    logic [VAL_W-1:0] t_rd_reg, q_rd_reg, part_rd_reg, pa_rd_reg, pb_rd_reg;
    logic [VAL_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] op_a, op_b;
    dp_cmd_t          s1_reg, s2_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] coef_reg;
    logic             done_reg;

    logic             ld_ok;
    logic [AW-1:0]    ld_addr, t_raddr, q_raddr, pa_raddr, pb_raddr, p_waddr;
    logic [PW-1:0]    part_raddr, part_waddr;
    logic             part_we, p_we;
    logic [VAL_W-1:0] p_wdata;

    // Product modulo x^8+x^4+x^3+x+1, one shift-and-add step per bit.
    function automatic logic [VAL_W-1:0] gf_mul(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] acc;
        logic [VAL_W-1:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < VAL_W; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = x[VAL_W-1] ? ({x[VAL_W-2:0], 1'b0} ^ 8'h1B) : {x[VAL_W-2:0], 1'b0};
        end
        return acc;
    endfunction

    // Row-major address of a matrix entry.
    function automatic logic [AW-1:0] ent_addr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Address decode for loads and for the read ports of each store.
    assign ld_ok      = (int'(cmd.row) < MAX_DIM) && (int'(cmd.col) < MAX_DIM);
    assign ld_addr    = ent_addr(cmd.row, cmd.col);
    assign t_raddr    = cmd.mac_b ? ent_addr(cmd.p, cmd.m) : ent_addr(cmd.p, cmd.l);
    assign q_raddr    = ent_addr(cmd.p, cmd.m);
    assign part_raddr = PW'(cmd.p);
    assign pa_raddr   = ent_addr(cmd.l, cmd.m);
    assign pb_raddr   = ent_addr(cmd.m, cmd.l);

    // Transform store.
    always_ff @(posedge aclk) begin
        if (cmd.ld_t && ld_ok) begin
            t_mem[ld_addr] <= cmd.value;
        end
        t_rd_reg <= t_mem[t_raddr];
    end

    // Quadratic form store.
    always_ff @(posedge aclk) begin
        if (cmd.ld_q && ld_ok) begin
            q_mem[ld_addr] <= cmd.value;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

    // Partial row store, written at the end of each first-pass sum.
    assign part_we    = s2_reg.mac && s2_reg.last && !s2_reg.mac_b;
    assign part_waddr = PW'(s2_reg.m);

    always_ff @(posedge aclk) begin
        if (part_we) begin
            part_mem[part_waddr] <= acc_next;
        end
        part_rd_reg <= part_mem[part_raddr];
    end

    // Product store: second-pass sums and folded entries share the write port.
    assign p_we    = (s2_reg.mac && s2_reg.last && s2_reg.mac_b) || s2_reg.fold;
    assign p_waddr = ent_addr(s2_reg.l, s2_reg.m);
    assign p_wdata = s2_reg.fold ? prod_reg : acc_next;

    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        pa_rd_reg <= p_mem[pa_raddr];
        pb_rd_reg <= p_mem[pb_raddr];
    end

    // Stage one: operand select and multiply, or the sum of an entry and its mirror.
    assign op_a      = s1_reg.mac_b ? part_rd_reg : t_rd_reg;
    assign op_b      = s1_reg.mac_b ? t_rd_reg : q_rd_reg;
    assign prod_next = s1_reg.fold ? (pa_rd_reg ^ pb_rd_reg) : gf_mul(op_a, op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    // Stage two: accumulate over the inner index.
    assign acc_next = (s2_reg.first ? '0 : acc_reg) ^ prod_reg;

    always_ff @(posedge aclk) begin
        if (s2_reg.mac) begin
            acc_reg <= acc_next;
        end
    end

    // Command pipeline that follows the data through both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
            s2_reg <= '0;
        end else begin
            s1_reg <= cmd;
            s2_reg <= s1_reg;
        end
    end

    // Result register; it holds a transaction until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_reg.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_reg.emit) begin
            coef_reg <= (s1_reg.emit_kind == EMIT_READ) ? pa_rd_reg : '0;
            done_reg <= (s1_reg.emit_kind == EMIT_DONE);
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign coefficient     = coef_reg;
    assign is_done         = done_reg;
    assign status.out_free = (!out_valid_reg || m_tready) && !s1_reg.emit;

endmodule

/* rtl/gf256_congruence_transform_top.sv */
// Top level of the GF(2^8) congruence transform block with its register port.
//
// Input transactions (s_tvalid/s_tready) carry a command in s_tuser: load a
// transform entry, load a quadratic form entry, compute, or read a packed
// coefficient. Loads give no result; compute and read each give one result
// transaction on m_tvalid/m_tready, with is_done in m_tuser.
// The block works on one command at a time. A read walks the packed rows,
// one per cycle, up to the packed row k of the coefficient (at most n).
// A compute runs a two-stage multiply-accumulate pipeline over the stores,
// one step per cycle.
// vars_in_use (byte address 0) sets n; the user must write it only while
// idle, as the block itself does not enforce it.
// A stalled receiver holds the result in the output register; the next
// command is still taken and waits only when it must emit its own result.
// Reset clears the control state and sets vars_in_use to 31; the matrix
// stores keep their contents undefined until written.
module gf256_congruence_transform_top #(
    parameter int MAX_DIM = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row[4:0], col[9:5], entry_value[17:10],
                                   // packed_index[27:18], zero[31:28]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // coefficient[7:0]
    output logic [0:0]  m_tuser,   // is_done[0]
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gct_pkg::*;

    logic [4:0]  vars_reg;
    logic        cfg_we;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [VAL_W-1:0] coefficient;
    logic        is_done;

    // Register port: zero wait states, one register at index zero.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_VARS);
    assign prdata = (paddr[2] == CFG_IDX_VARS) ? {27'd0, vars_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vars_reg <= VARS_RESET;
        end else if (cfg_we) begin
            vars_reg <= pwdata[4:0];
        end
    end

    gct_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .cmd_code     (s_tuser),
        .row          (s_tdata[4:0]),
        .col          (s_tdata[9:5]),
        .entry_value  (s_tdata[17:10]),
        .packed_index (s_tdata[27:18]),
        .vars_in_use  (vars_reg),
        .status       (status),
        .cmd          (cmd)
    );

    gct_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .coefficient (coefficient),
        .is_done     (is_done),
        .status      (status)
    );

    assign m_tdata    = coefficient;
    assign m_tuser[0] = is_done;

endmodule

/* rtl/gct_checker.sv */
// Port-level checker for the congruence transform block and its bind.
`include "gf256_congruence_transform_top_assert.svh"

module gct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pready
);
    import gct_pkg::*;

    // A stalled result transaction keeps its payload.
    `GCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // A completion report carries no coefficient.
    `GCT_ASSERT_SAME(a_done_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 8'd0, "done result with nonzero coefficient")

    // Compute and read occupy the block for at least the following cycle.
    `GCT_ASSERT_NEXT(a_busy_after, aclk, aresetn, s_tvalid && s_tready && (s_tuser == CMD_COMPUTE || s_tuser == CMD_READ), !s_tready, "ready right after compute or read")

    // The register port never inserts wait states.
    `GCT_ASSERT_SAME(a_no_wait, aclk, aresetn, psel && penable, pready, "register access stalled")

endmodule

bind gf256_congruence_transform_top gct_checker u_gct_checker (.*);

/* dv/tb_gf256_congruence_transform_top.sv */
// Self-checking testbench for the GF(2^8) congruence transform block.
`timescale 1ns / 1ps

module tb_gf256_congruence_transform_top;
    import gct_pkg::*;

    localparam int          DIM_MAX     = 32;
    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          LOAD_SETTLE = 16;
    localparam int          END_TAIL    = 50;
    localparam logic [2:0]  VARS_ADDR   = 3'(CFG_IDX_VARS) << 2;

    typedef struct {
        logic [7:0] coef;
        logic       done;
    } coef_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: the three matrices and the variable count.
    logic [7:0]   t_mat [DIM_MAX][DIM_MAX];
    logic [7:0]   q_mat [DIM_MAX][DIM_MAX];
    logic [7:0]   p_mat [DIM_MAX][DIM_MAX];
    logic [4:0]   vars_cfg;

    coef_result_t pending_results [$];

    int           mismatch_count;
    int           burst_left;
    int           hold_request;
    int           n_loads;
    int           n_computes;
    int           n_reads;
    int           n_settings;
    int           max_dim_seen;

    gf256_congruence_transform_top #(
        .MAX_DIM (DIM_MAX)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // GF(2^8) multiply modulo x^8+x^4+x^3+x+1.
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        int         i;
        x   = {1'b0, a};
        acc = 8'h00;
        for (i = 0; i < 8; i++) begin
            if (b[i]) acc ^= x[7:0];
            x = x << 1;
            if (x[8]) x ^= 9'h11B;
        end
        return acc;
    endfunction

    // P = transpose(T) * Q * T, then fold the lower triangle into the upper one.
    function automatic void form_congruence();
        logic [7:0] row_buf [DIM_MAX];
        logic [7:0] acc;
        int         d;
        int         l;
        int         m;
        int         p;
        d = int'(vars_cfg) + 1;
        for (l = 0; l < d; l++) begin
            for (m = 0; m < d; m++) begin
                acc = 8'h00;
                for (p = 0; p < d; p++) acc ^= gf_product(t_mat[p][l], q_mat[p][m]);
                row_buf[m] = acc;
            end
            for (m = 0; m < d; m++) begin
                acc = 8'h00;
                for (p = 0; p < d; p++) acc ^= gf_product(row_buf[p], t_mat[p][m]);
                p_mat[l][m] = acc;
            end
        end
        for (l = 0; l < d; l++) begin
            for (m = l + 1; m < d; m++) begin
                p_mat[l][m] ^= p_mat[m][l];
                p_mat[m][l] = 8'h00;
            end
        end
    endfunction

    // Coefficient at a position of the packed public-key order.
    function automatic logic [7:0] packed_coefficient(input logic [9:0] idx);
        int n;
        int k;
        int l;
        int pos;
        n   = int'(vars_cfg);
        pos = 0;
        for (k = 0; k < n; k++) begin
            for (l = k; l < n; l++) begin
                if (pos == int'(idx)) return p_mat[k][l];
                pos++;
            end
        end
        for (k = 0; k <= n; k++) begin
            if (pos == int'(idx)) return p_mat[k][n];
            pos++;
        end
        return 8'h00;
    endfunction

    function automatic int coef_count();
        return ((int'(vars_cfg) + 1) * (int'(vars_cfg) + 2)) / 2;
    endfunction

    // Byte values biased toward the field extremes.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Update the predictor for one accepted command and queue its result.
    function automatic void predict_command(input logic [1:0] cmd, input logic [4:0] row,
                                            input logic [4:0] col, input logic [7:0] val,
                                            input logic [9:0] pidx);
        coef_result_t r;
        case (cmd)
            CMD_LOAD_T: begin
                t_mat[row][col] = val;
                n_loads++;
            end
            CMD_LOAD_Q: begin
                q_mat[row][col] = val;
                n_loads++;
            end
            CMD_COMPUTE: begin
                form_congruence();
                r.coef = 8'h00;
                r.done = 1'b1;
                pending_results.push_back(r);
                n_computes++;
                if (int'(vars_cfg) + 1 > max_dim_seen) max_dim_seen = int'(vars_cfg) + 1;
            end
            default: begin
                r.coef = packed_coefficient(pidx);
                r.done = 1'b0;
                pending_results.push_back(r);
                n_reads++;
            end
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch in %s: expected %h, got %h at %0t", what, exp_v, act_v, $realtime);
    endtask

    // Send one command transaction, with bursts of random length and gaps between them.
    task automatic send_command(input logic [1:0] cmd, input logic [4:0] row,
                                input logic [4:0] col, input logic [7:0] val,
                                input logic [9:0] pidx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 :
                         (($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 5));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, pidx, val, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        predict_command(cmd, row, col, val, pidx);
    endtask

    task automatic send_load(input logic [1:0] cmd, input logic [4:0] row,
                             input logic [4:0] col, input logic [7:0] val);
        send_command(cmd, row, col, val, 10'($urandom_range(0, 1023)));
    endtask

    task automatic send_compute();
        send_command(CMD_COMPUTE, 5'($urandom), 5'($urandom), 8'($urandom),
                     10'($urandom_range(0, 1023)));
    endtask

    task automatic send_read(input logic [9:0] pidx);
        send_command(CMD_READ, 5'($urandom), 5'($urandom), 8'($urandom), pidx);
    endtask

    // Read index mostly inside the packed range, sometimes anywhere in the field.
    function automatic logic [9:0] pick_read_index();
        if ($urandom_range(0, 4) == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, coef_count() - 1));
    endfunction

    // Stop sending and wait until every expected result has come back.
    task automatic wait_idle(input int tail);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_vars(input logic [4:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VARS_ADDR;
        pwdata  <= {27'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        vars_cfg = value;
        n_settings++;
    endtask

    // Register read, compared against the predictor's copy.
    task automatic check_vars_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= VARS_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {27'd0, vars_cfg}) note_mismatch("vars_in_use readback",
                                                        {27'd0, vars_cfg}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: ready pattern that changes mode, plus long hold-offs on request.
    initial begin : rx_pattern
        int stall_pct;
        int run_left;
        int held;
        stall_pct = 0;
        run_left  = 0;
        held      = 0;
        m_tready  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held > 0) begin
                m_tready <= 1'b0;
                held--;
            end else begin
                if (run_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    run_left = $urandom_range(10, 200);
                end
                run_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge aclk) begin
        coef_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result (coefficient)", 32'h0, {24'd0, m_tdata});
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.coef)
                    note_mismatch("coefficient", {24'd0, want.coef}, {24'd0, m_tdata});
                if (m_tuser[0] !== want.done)
                    note_mismatch("is_done", {31'd0, want.done}, {31'd0, m_tuser[0]});
            end
        end
    end

    // Register value after reset.
    task automatic test_register_reset();
        check_vars_readback();
    endtask

    // Zero variables: dimension one, a single coefficient P[0][0].
    task automatic test_zero_variables();
        write_vars(5'd0);
        send_load(CMD_LOAD_T, 5'd0, 5'd0, 8'hFF);
        send_load(CMD_LOAD_Q, 5'd0, 5'd0, 8'hFF);
        send_load(CMD_LOAD_Q, 5'd31, 5'd31, 8'h00);
        send_compute();
        send_read(10'd0);
        send_read(10'd1);
        wait_idle(LOAD_SETTLE);
        check_vars_readback();
    endtask

    // One variable: full 2x2 load, compute, every packed position and out-of-range reads.
    task automatic test_one_variable();
        write_vars(5'd1);
        send_load(CMD_LOAD_T, 5'd0, 5'd0, 8'h80);
        send_load(CMD_LOAD_T, 5'd0, 5'd1, 8'hFF);
        send_load(CMD_LOAD_T, 5'd1, 5'd0, 8'h01);
        send_load(CMD_LOAD_T, 5'd1, 5'd1, 8'h1B);
        send_load(CMD_LOAD_Q, 5'd0, 5'd0, 8'hFF);
        send_load(CMD_LOAD_Q, 5'd0, 5'd1, 8'h80);
        send_load(CMD_LOAD_Q, 5'd1, 5'd0, 8'h53);
        send_load(CMD_LOAD_Q, 5'd1, 5'd1, 8'h01);
        send_compute();
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'd2);
        send_read(10'd3);
        send_read(10'd1023);
        wait_idle(LOAD_SETTLE);
    endtask

    // Largest setting: fill both stores completely, compute, sample the packed output.
    task automatic test_full_size();
        int r;
        int c;
        int i;
        write_vars(5'd31);
        check_vars_readback();
        for (r = 0; r < DIM_MAX; r++) begin
            for (c = 0; c < DIM_MAX; c++) begin
                send_load(CMD_LOAD_T, 5'(r), 5'(c), pick_byte());
                send_load(CMD_LOAD_Q, 5'(r), 5'(c), pick_byte());
            end
        end
        send_compute();
        send_read(10'd0);
        send_read(10'd527);
        send_read(10'd528);
        for (i = 0; i < 20; i++) send_read(pick_read_index());
        wait_idle(LOAD_SETTLE);
    endtask

    // Receiver holds off for a long stretch while reads keep coming.
    task automatic test_backpressure();
        int i;
        write_vars(5'd3);
        send_compute();
        wait_idle(LOAD_SETTLE);
        hold_request = 400;
        for (i = 0; i < 40; i++) begin
            if ($urandom_range(0, 4) == 0)
                send_load(($urandom_range(0, 1) != 0) ? CMD_LOAD_Q : CMD_LOAD_T,
                          5'($urandom), 5'($urandom), pick_byte());
            else
                send_read(pick_read_index());
        end
        wait_idle(LOAD_SETTLE);
    endtask

    // Random phases: each picks a setting, computes first, then mixes all commands.
    task automatic test_random_phases();
        int phase;
        int i;
        int pick;
        logic [4:0] vars_next;
        for (phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 9))
                0:       vars_next = 5'd0;
                1:       vars_next = 5'($urandom_range(7, 10));
                default: vars_next = 5'($urandom_range(1, 6));
            endcase
            write_vars(vars_next);
            if ($urandom_range(0, 2) == 0) check_vars_readback();
            send_compute();
            for (i = 0; i < 40; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 22)
                    send_load(CMD_LOAD_T, 5'($urandom), 5'($urandom), pick_byte());
                else if (pick < 44)
                    send_load(CMD_LOAD_Q, 5'($urandom), 5'($urandom), pick_byte());
                else if (pick < 53)
                    send_compute();
                else
                    send_read(pick_read_index());
            end
            wait_idle(LOAD_SETTLE);
        end
    endtask

    // Drain, summarize and give the verdict.
    task automatic finish_run();
        wait_idle(END_TAIL);
        $display("Run covered %0d loads, %0d computes and %0d reads over %0d settings.",
                 n_loads, n_computes, n_reads, n_settings);
        $display("Largest matrix dimension computed: %0d; mismatches: %0d.",
                 max_dim_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    endtask

    // Test sequence.
    initial begin
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 32'd0;
        s_tuser        <= CMD_LOAD_T;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= VARS_ADDR;
        pwdata         <= 32'd0;
        vars_cfg       = VARS_RESET;
        mismatch_count = 0;
        burst_left     = 0;
        hold_request   = 0;
        n_loads        = 0;
        n_computes     = 0;
        n_reads        = 0;
        n_settings     = 0;
        max_dim_seen   = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_zero_variables();
        test_one_variable();
        test_full_size();
        test_backpressure();
        test_random_phases();
        finish_run();
    end

endmodule

/* gf256_congruence_transform_top.f */
+incdir+rtl
rtl/gct_pkg.sv
rtl/gct_ctrl.sv
rtl/gct_datapath.sv
rtl/gf256_congruence_transform_top.sv
rtl/gct_checker.sv
dv/tb_gf256_congruence_transform_top.sv
